// ===== hw/rtl/bfsp_pkg.sv =====
package bfsp_pkg;

   localparam int DEF_MAX_VERTICES = 256;
   localparam int DEF_MAX_EDGES    = 4096;
   localparam int DEF_WEIGHT_BITS  = 32;

   localparam int DIST_BITS   = 48;
   localparam int VERTEX_BITS = 8;
   localparam int COUNT_BITS  = 9;
   localparam int INPUT_WEIGHT_BITS = 32;

   localparam logic [DIST_BITS-1:0] DIST_MAX = {1'b0, {(DIST_BITS-1){1'b1}}};
   localparam logic [DIST_BITS-1:0] DIST_MIN = {1'b1, {(DIST_BITS-1){1'b0}}};

   typedef enum logic [1:0] {
      ACT_ADD   = 2'd0,
      ACT_RUN   = 2'd1,
      ACT_READ  = 2'd2,
      ACT_CLEAR = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_RANGE    = 2'd1,
      STATUS_FULL     = 2'd2,
      STATUS_NEGATIVE = 2'd3
   } status_type;

endpackage

// ===== hw/rtl/bfsp_ram.sv =====
module bfsp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/bellman_ford_shortest_paths.sv =====
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_ready  action, first_vertex, second_vertex, edge_weight
// rsp_      out        rsp_valid/rsp_ready  status, distance, reachable
// csr_      in         csr_wr_en            vertex_count, taken at once
//
// Add, clear and rejected items answer in the cycle after acceptance; a read answers from ST_READ,
// after the registered distance memory read. A run walks the edge table one edge at a time: ST_SCAN
// and ST_EDGE for a skipped edge; ST_SCAN, ST_EDGE, ST_DIST and ST_TEST for one whose source is
// reached; ST_SCAN closes each pass, over at most vertex_count-1 passes and a check pass.
// Reset is synchronous; it empties the edge table and marks every vertex unreachable.
// A stalled result holds the block until it is taken.
module bellman_ford_shortest_paths
   import bfsp_pkg::*;
#(
   parameter int MAX_VERTICES = DEF_MAX_VERTICES,
   parameter int MAX_EDGES    = DEF_MAX_EDGES,
   parameter int WEIGHT_BITS  = DEF_WEIGHT_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_action,
   input  logic [VERTEX_BITS-1:0]             req_first_vertex,
   input  logic [VERTEX_BITS-1:0]             req_second_vertex,
   input  logic signed [INPUT_WEIGHT_BITS-1:0] req_edge_weight,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [1:0]                         rsp_status,
   output logic signed [DIST_BITS-1:0]        rsp_distance,
   output logic                               rsp_reachable,
   input  logic                               csr_wr_en,
   input  logic [COUNT_BITS-1:0]              csr_wr_data
);

   localparam int CW   = (WEIGHT_BITS < INPUT_WEIGHT_BITS) ? WEIGHT_BITS : INPUT_WEIGHT_BITS;
   localparam int VW   = $clog2(MAX_VERTICES);
   localparam int NW   = $clog2(MAX_VERTICES + 1);
   localparam int NW1  = NW + 1;
   localparam int EW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int SW   = $clog2(MAX_EDGES + 1);
   localparam int EDW  = 2 * VERTEX_BITS + CW;
   localparam int CCMP = (NW > COUNT_BITS) ? NW : COUNT_BITS;
   localparam int VCMP = (NW > VERTEX_BITS) ? NW : VERTEX_BITS;
   localparam int SUMW = DIST_BITS + 1;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_READ = 6'b000010,
      ST_SCAN = 6'b000100,
      ST_EDGE = 6'b001000,
      ST_DIST = 6'b010000,
      ST_TEST = 6'b100000
   } state_type;

   state_type                 state_ff, state_in;
   logic [COUNT_BITS-1:0]     vertex_count_ff;
   logic [SW-1:0]             edges_stored_ff, edges_stored_in;
   logic [SW-1:0]             edge_idx_ff, edge_idx_in;
   logic [NW-1:0]             pass_ff, pass_in;
   logic                      check_mode_ff, check_mode_in;
   logic                      changed_ff, changed_in;
   logic [MAX_VERTICES-1:0]   reached_ff, reached_in;
   logic                      read_reach_ff, read_reach_in;
   logic [DIST_BITS-1:0]      cand_ff, cand_in;
   logic [DIST_BITS-1:0]      dv_ff, dv_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [1:0]                rsp_status_ff, rsp_status_in;
   logic [DIST_BITS-1:0]      rsp_distance_ff, rsp_distance_in;
   logic                      rsp_reachable_ff, rsp_reachable_in;

   logic [NW-1:0]             n_active;
   logic [CCMP-1:0]           vc_wide;
   logic                      first_bad, second_bad;
   logic                      edge_wr;
   logic [EDW-1:0]            edge_wr_data, edge_q;
   logic [VERTEX_BITS-1:0]    edge_u, edge_v;
   logic [CW-1:0]             edge_cost;
   logic                      dist_wr;
   logic [VW-1:0]             dist_wr_addr, dist_u_addr;
   logic [DIST_BITS-1:0]      dist_wr_data, dist_u_q, dist_v_q;
   logic [SUMW-1:0]           sum_wide;
   logic                      edge_bad, relax;

   assign vc_wide = CCMP'(vertex_count_ff);

   always_comb begin
      if (vc_wide == '0) begin
         n_active = NW'(1);
      end else if (vc_wide > CCMP'(MAX_VERTICES)) begin
         n_active = NW'(MAX_VERTICES);
      end else begin
         n_active = NW'(vc_wide);
      end
   end

   assign first_bad  = VCMP'(req_first_vertex) >= VCMP'(n_active);
   assign second_bad = VCMP'(req_second_vertex) >= VCMP'(n_active);

   assign edge_u    = edge_q[EDW-1 -: VERTEX_BITS];
   assign edge_v    = edge_q[CW +: VERTEX_BITS];
   assign edge_cost = edge_q[CW-1:0];
   assign edge_bad  = (VCMP'(edge_u) >= VCMP'(n_active)) || (VCMP'(edge_v) >= VCMP'(n_active))
                      || !reached_ff[VW'(edge_u)];

   assign sum_wide = {dist_u_q[DIST_BITS-1], dist_u_q}
                     + {{(SUMW-CW){edge_cost[CW-1]}}, edge_cost};
   assign relax    = !reached_ff[VW'(edge_v)] || ($signed(cand_ff) < $signed(dv_ff));

   assign edge_wr_data = {req_first_vertex, req_second_vertex, req_edge_weight[CW-1:0]};
   assign dist_u_addr  = (state_ff == ST_IDLE) ? VW'(req_first_vertex) : VW'(edge_u);

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in         = state_ff;
      edges_stored_in  = edges_stored_ff;
      edge_idx_in      = edge_idx_ff;
      pass_in          = pass_ff;
      check_mode_in    = check_mode_ff;
      changed_in       = changed_ff;
      reached_in       = reached_ff;
      read_reach_in    = read_reach_ff;
      cand_in          = cand_ff;
      dv_in            = dv_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_status_in    = rsp_status_ff;
      rsp_distance_in  = rsp_distance_ff;
      rsp_reachable_in = rsp_reachable_ff;
      edge_wr          = 1'b0;
      dist_wr          = 1'b0;
      dist_wr_addr     = VW'(edge_v);
      dist_wr_data     = cand_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               rsp_distance_in  = '0;
               rsp_reachable_in = 1'b0;
               rsp_status_in    = STATUS_OK;
               case (action_type'(req_action))
                  ACT_ADD: begin
                     rsp_valid_in = 1'b1;
                     if (first_bad || second_bad) begin
                        rsp_status_in = STATUS_RANGE;
                     end else if (edges_stored_ff >= SW'(MAX_EDGES)) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        edge_wr         = 1'b1;
                        edges_stored_in = SW'(edges_stored_ff + 1'b1);
                     end
                  end
                  ACT_RUN: begin
                     if (first_bad) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_RANGE;
                     end else begin
                        reached_in                        = '0;
                        reached_in[VW'(req_first_vertex)] = 1'b1;
                        dist_wr       = 1'b1;
                        dist_wr_addr  = VW'(req_first_vertex);
                        dist_wr_data  = '0;
                        edge_idx_in   = '0;
                        pass_in       = '0;
                        changed_in    = 1'b0;
                        check_mode_in = (n_active == NW'(1));
                        state_in      = ST_SCAN;
                     end
                  end
                  ACT_READ: begin
                     if (first_bad) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_RANGE;
                     end else begin
                        read_reach_in = reached_ff[VW'(req_first_vertex)];
                        state_in      = ST_READ;
                     end
                  end
                  default: begin
                     rsp_valid_in    = 1'b1;
                     edges_stored_in = '0;
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_valid_in     = 1'b1;
            rsp_status_in    = STATUS_OK;
            rsp_distance_in  = read_reach_ff ? dist_u_q : '0;
            rsp_reachable_in = read_reach_ff;
            state_in         = ST_IDLE;
         end
         ST_SCAN: begin
            if (edge_idx_ff == edges_stored_ff) begin
               edge_idx_in = '0;
               changed_in  = 1'b0;
               if (check_mode_ff || !changed_ff) begin
                  rsp_valid_in     = 1'b1;
                  rsp_status_in    = STATUS_OK;
                  rsp_distance_in  = '0;
                  rsp_reachable_in = 1'b0;
                  state_in         = ST_IDLE;
               end else if (NW1'(pass_ff) + NW1'(2) < NW1'(n_active)) begin
                  pass_in = NW'(pass_ff + 1'b1);
               end else begin
                  check_mode_in = 1'b1;
               end
            end else begin
               state_in = ST_EDGE;
            end
         end
         ST_EDGE: begin
            if (edge_bad) begin
               edge_idx_in = SW'(edge_idx_ff + 1'b1);
               state_in    = ST_SCAN;
            end else begin
               state_in = ST_DIST;
            end
         end
         ST_DIST: begin
            if (sum_wide[SUMW-1] != sum_wide[SUMW-2]) begin
               cand_in = sum_wide[SUMW-1] ? DIST_MIN : DIST_MAX;
            end else begin
               cand_in = sum_wide[DIST_BITS-1:0];
            end
            dv_in    = dist_v_q;
            state_in = ST_TEST;
         end
         ST_TEST: begin
            if (relax && check_mode_ff) begin
               rsp_valid_in     = 1'b1;
               rsp_status_in    = STATUS_NEGATIVE;
               rsp_distance_in  = '0;
               rsp_reachable_in = 1'b0;
               state_in         = ST_IDLE;
            end else begin
               if (relax) begin
                  dist_wr                  = 1'b1;
                  reached_in[VW'(edge_v)]  = 1'b1;
                  changed_in               = 1'b1;
               end
               edge_idx_in = SW'(edge_idx_ff + 1'b1);
               state_in    = ST_SCAN;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         vertex_count_ff <= COUNT_BITS'(256);
         edges_stored_ff <= '0;
         reached_ff      <= '0;
         rsp_valid_ff    <= 1'b0;
         edge_idx_ff     <= '0;
         pass_ff         <= '0;
         check_mode_ff   <= 1'b0;
         changed_ff      <= 1'b0;
      end else begin
         state_ff        <= state_in;
         edges_stored_ff <= edges_stored_in;
         reached_ff      <= reached_in;
         rsp_valid_ff    <= rsp_valid_in;
         edge_idx_ff     <= edge_idx_in;
         pass_ff         <= pass_in;
         check_mode_ff   <= check_mode_in;
         changed_ff      <= changed_in;
         if (csr_wr_en) begin
            vertex_count_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      read_reach_ff    <= read_reach_in;
      cand_ff          <= cand_in;
      dv_ff            <= dv_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_distance_ff  <= rsp_distance_in;
      rsp_reachable_ff <= rsp_reachable_in;
   end

   bfsp_ram #(
      .WIDTH (EDW),
      .DEPTH (MAX_EDGES)
   ) u_edge_ram (
      .clock   (clock),
      .wr_en   (edge_wr),
      .wr_addr (edges_stored_ff[EW-1:0]),
      .wr_data (edge_wr_data),
      .rd_addr (edge_idx_ff[EW-1:0]),
      .rd_data (edge_q)
   );

   // Two copies of the distance table give the source and destination reads together.
   bfsp_ram #(
      .WIDTH (DIST_BITS),
      .DEPTH (MAX_VERTICES)
   ) u_dist_src_ram (
      .clock   (clock),
      .wr_en   (dist_wr),
      .wr_addr (dist_wr_addr),
      .wr_data (dist_wr_data),
      .rd_addr (dist_u_addr),
      .rd_data (dist_u_q)
   );

   bfsp_ram #(
      .WIDTH (DIST_BITS),
      .DEPTH (MAX_VERTICES)
   ) u_dist_dst_ram (
      .clock   (clock),
      .wr_en   (dist_wr),
      .wr_addr (dist_wr_addr),
      .wr_data (dist_wr_data),
      .rd_addr (VW'(edge_v)),
      .rd_data (dist_v_q)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_distance  = rsp_distance_ff;
   assign rsp_reachable = rsp_reachable_ff;

`ifndef SYNTHESIS
   a_edges_bounded: assert property (@(posedge clock) disable iff (reset)
      edges_stored_ff <= SW'(MAX_EDGES))
      else $error("edge count exceeds the table depth");

   a_scan_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE && state_ff != ST_READ) |-> edge_idx_ff <= edges_stored_ff)
      else $error("edge walk ran past the stored edges");

   a_run_end_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TEST && relax && check_mode_ff) |=>
      (rsp_valid_ff && rsp_status_ff == STATUS_NEGATIVE && state_ff == ST_IDLE))
      else $error("negative cycle not reported");

   a_negative_no_distance: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != STATUS_OK) |-> (!rsp_reachable_ff && rsp_distance_ff == '0))
      else $error("error item carries a distance");
`endif

endmodule
